// ===== src/rat_pkg.sv =====
// Package for the length-prefixed string array tokenizer.
// Holds transaction types, parser phase codes, verdict codes and byte constants.
// No dependencies.
package rat_pkg;

   localparam int LEN_BITS_DEF = 32;

   localparam logic [7:0] CHAR_STAR   = 8'h2A;
   localparam logic [7:0] CHAR_DOLLAR = 8'h24;
   localparam logic [7:0] CHAR_CR     = 8'h0D;
   localparam logic [7:0] CHAR_LF     = 8'h0A;
   localparam logic [7:0] CHAR_ZERO   = 8'h30;
   localparam logic [7:0] CHAR_NINE   = 8'h39;

   localparam logic [1:0] TRAILER_LEN = 2'd2;

   localparam logic [1:0] VERDICT_OK      = 2'd0;
   localparam logic [1:0] VERDICT_PARTIAL = 2'd1;
   localparam logic [1:0] VERDICT_REJECT  = 2'd2;

   typedef enum logic [7:0] {
      PH_ARR_START   = 8'b0000_0001,
      PH_ARR_DIGITS  = 8'b0000_0010,
      PH_BULK_START  = 8'b0000_0100,
      PH_BULK_DIGITS = 8'b0000_1000,
      PH_DATA        = 8'b0001_0000,
      PH_TRAILER     = 8'b0010_0000,
      PH_STOP_PART   = 8'b0100_0000,
      PH_STOP_REJ    = 8'b1000_0000
   } phase_type;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       in_last;
   } req_type;

   typedef struct packed {
      logic [7:0] token_byte;
      logic       byte_valid;
      logic       token_last;
      logic       msg_done;
      logic [1:0] verdict;
   } rsp_type;

endpackage

// ===== src/rat_core.sv =====
// Parser state and per-byte next-state logic of the string array tokenizer.
// Depends on rat_pkg for transaction types, phase codes and constants.
module rat_core #(
   parameter int LEN_BITS = rat_pkg::LEN_BITS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             step,
   input  rat_pkg::req_type item,
   output rat_pkg::rsp_type result
);

   rat_pkg::phase_type  phase_ff, phase_in;
   logic                saw_cr_ff, saw_cr_in;
   logic [LEN_BITS-1:0] accum_ff, accum_in;
   logic                seen_ff, seen_in;
   logic [LEN_BITS-1:0] header_ff, header_in;
   logic [LEN_BITS-1:0] left_ff, left_in;
   logic [LEN_BITS:0]   tokens_ff, tokens_in;
   logic [1:0]          trailer_ff, trailer_in;

   logic [LEN_BITS+3:0] accum_wide;
   logic [LEN_BITS+3:0] next_num;
   logic [3:0]          digit;
   logic                is_digit;
   logic                in_digits;
   logic                hdr_done;
   logic                hdr_bad;

   assign digit      = 4'(item.in_byte - rat_pkg::CHAR_ZERO);
   assign is_digit   = (item.in_byte >= rat_pkg::CHAR_ZERO) &&
                       (item.in_byte <= rat_pkg::CHAR_NINE);
   assign accum_wide = {4'd0, accum_ff};
   assign next_num   = (accum_wide << 3) + (accum_wide << 1) + {{LEN_BITS{1'b0}}, digit};
   assign in_digits  = (phase_ff == rat_pkg::PH_ARR_DIGITS) ||
                       (phase_ff == rat_pkg::PH_BULK_DIGITS);

   always_comb begin
      hdr_done  = 1'b0;
      hdr_bad   = 1'b0;
      saw_cr_in = saw_cr_ff;
      accum_in  = accum_ff;
      seen_in   = seen_ff;
      if (in_digits) begin
         if (saw_cr_ff) begin
            if (item.in_byte == rat_pkg::CHAR_LF) begin
               hdr_done = 1'b1;
            end else begin
               hdr_bad = 1'b1;
            end
         end else if (item.in_byte == rat_pkg::CHAR_CR) begin
            if (seen_ff) begin
               saw_cr_in = 1'b1;
            end else begin
               hdr_bad = 1'b1;
            end
         end else if (!is_digit || (next_num[LEN_BITS+3:LEN_BITS] != 4'd0)) begin
            hdr_bad = 1'b1;
         end else begin
            accum_in = next_num[LEN_BITS-1:0];
            seen_in  = 1'b1;
         end
      end
   end

   always_comb begin
      phase_in          = phase_ff;
      header_in         = header_ff;
      left_in           = left_ff;
      tokens_in         = tokens_ff;
      trailer_in        = trailer_ff;
      result.token_byte = 8'd0;
      result.byte_valid = 1'b0;
      result.token_last = 1'b0;
      result.msg_done   = 1'b0;
      result.verdict    = rat_pkg::VERDICT_OK;
      case (phase_ff)
         rat_pkg::PH_ARR_START: begin
            phase_in = (item.in_byte == rat_pkg::CHAR_STAR) ? rat_pkg::PH_ARR_DIGITS
                                                            : rat_pkg::PH_STOP_REJ;
         end
         rat_pkg::PH_ARR_DIGITS: begin
            if (hdr_bad) begin
               phase_in = rat_pkg::PH_STOP_REJ;
            end else if (hdr_done) begin
               header_in = accum_ff;
               phase_in  = rat_pkg::PH_BULK_START;
            end
         end
         rat_pkg::PH_BULK_START: begin
            phase_in = (item.in_byte == rat_pkg::CHAR_DOLLAR) ? rat_pkg::PH_BULK_DIGITS
                                                              : rat_pkg::PH_STOP_PART;
         end
         rat_pkg::PH_BULK_DIGITS: begin
            if (hdr_bad) begin
               phase_in = rat_pkg::PH_STOP_REJ;
            end else if (hdr_done) begin
               left_in = accum_ff;
               if (accum_ff == '0) begin
                  result.token_last = 1'b1;
                  if (tokens_ff != '1) tokens_in = tokens_ff + 1'b1;
                  trailer_in = rat_pkg::TRAILER_LEN;
                  phase_in   = rat_pkg::PH_TRAILER;
               end else begin
                  phase_in = rat_pkg::PH_DATA;
               end
            end
         end
         rat_pkg::PH_DATA: begin
            result.token_byte = item.in_byte;
            result.byte_valid = 1'b1;
            left_in           = left_ff - 1'b1;
            if (left_ff == {{(LEN_BITS-1){1'b0}}, 1'b1}) begin
               result.token_last = 1'b1;
               if (tokens_ff != '1) tokens_in = tokens_ff + 1'b1;
               trailer_in = rat_pkg::TRAILER_LEN;
               phase_in   = rat_pkg::PH_TRAILER;
            end
         end
         rat_pkg::PH_TRAILER: begin
            trailer_in = trailer_ff - 1'b1;
            if (trailer_ff == 2'd1) phase_in = rat_pkg::PH_BULK_START;
         end
         default: begin
         end
      endcase
      if (item.in_last) begin
         result.msg_done = 1'b1;
         if (phase_in == rat_pkg::PH_STOP_PART) begin
            result.verdict = rat_pkg::VERDICT_PARTIAL;
         end else if (phase_in == rat_pkg::PH_BULK_START &&
                      tokens_in == {1'b0, header_in}) begin
            result.verdict = rat_pkg::VERDICT_OK;
         end else begin
            result.verdict = rat_pkg::VERDICT_REJECT;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= rat_pkg::PH_ARR_START;
         saw_cr_ff  <= 1'b0;
         accum_ff   <= '0;
         seen_ff    <= 1'b0;
         header_ff  <= '0;
         left_ff    <= '0;
         tokens_ff  <= '0;
         trailer_ff <= 2'd0;
      end else if (step) begin
         if (item.in_last) begin
            phase_ff   <= rat_pkg::PH_ARR_START;
            saw_cr_ff  <= 1'b0;
            accum_ff   <= '0;
            seen_ff    <= 1'b0;
            header_ff  <= '0;
            left_ff    <= '0;
            tokens_ff  <= '0;
            trailer_ff <= 2'd0;
         end else begin
            phase_ff   <= phase_in;
            header_ff  <= header_in;
            left_ff    <= left_in;
            tokens_ff  <= tokens_in;
            trailer_ff <= trailer_in;
            if (phase_in != phase_ff) begin
               saw_cr_ff <= 1'b0;
               accum_ff  <= '0;
               seen_ff   <= 1'b0;
            end else begin
               saw_cr_ff <= saw_cr_in;
               accum_ff  <= accum_in;
               seen_ff   <= seen_in;
            end
         end
      end
   end

`ifndef ASSERT_OFF
   a_data_has_bytes: assert property (@(posedge clock) disable iff (reset)
      phase_ff == rat_pkg::PH_DATA |-> left_ff != '0)
      else $error("data phase with no bytes left");
   a_trailer_count: assert property (@(posedge clock) disable iff (reset)
      phase_ff == rat_pkg::PH_TRAILER |-> trailer_ff != 2'd0)
      else $error("trailer phase with no bytes left");
   a_cr_after_digit: assert property (@(posedge clock) disable iff (reset)
      saw_cr_ff |-> seen_ff && in_digits)
      else $error("CR recorded without digits");
`endif

endmodule

// ===== src/resp_array_tokenizer.sv =====
// Top level of the length-prefixed string array tokenizer.
// Each accepted byte's result is registered in the output register, or in the skid entry while the output is stalled.
// Throughput: one byte per cycle while the output flows; a second output entry takes one more byte during a stall.
// Reset: synchronous; parser returns to waiting for the array header, buffer empties.
// The parser also returns to that state after every byte flagged as final.
// Depends on rat_pkg and rat_core.
module resp_array_tokenizer #(
   parameter int LEN_BITS = rat_pkg::LEN_BITS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  rat_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output rat_pkg::rsp_type rsp_data
);

   rat_pkg::rsp_type result;
   rat_pkg::rsp_type out_ff;
   rat_pkg::rsp_type skid_ff;
   logic             out_valid_ff;
   logic             skid_valid_ff;
   logic             accept;
   logic             out_free;

   assign req_stall = skid_valid_ff;
   assign accept    = req_valid && !skid_valid_ff;
   assign out_free  = !out_valid_ff || !rsp_stall;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

   rat_core #(
      .LEN_BITS(LEN_BITS)
   ) u_core (
      .clock (clock),
      .reset (reset),
      .step  (accept),
      .item  (req_data),
      .result(result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (out_free) begin
         if (skid_valid_ff) begin
            out_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end else begin
            out_valid_ff <= accept;
         end
      end else if (accept) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free) begin
         out_ff <= skid_valid_ff ? skid_ff : result;
      end else if (accept) begin
         skid_ff <= result;
      end
   end

`ifndef ASSERT_OFF
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry held with empty output register");
   a_skid_drains: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff && !rsp_stall |=> out_valid_ff && !skid_valid_ff)
      else $error("skid entry not moved forward");
   a_verdict_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.msg_done |-> rsp_data.verdict == rat_pkg::VERDICT_OK)
      else $error("verdict set on a byte that is not final");
`endif

endmodule

// ===== sim/rat_token_checker.sv =====
// Checker for the string array tokenizer: watches both channels, predicts each result
// from the accepted bytes and compares it with what the block returns.
// Depends on rat_pkg.
`timescale 1ns / 1ps

module rat_token_checker (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_stall,
   input  rat_pkg::req_type req_data,
   input  logic             rsp_valid,
   input  logic             rsp_stall,
   input  rat_pkg::rsp_type rsp_data,
   output int               fail_count,
   output int               pending
);

   localparam logic [63:0] NUM_LIMIT = {64{1'b1}} >> (64 - rat_pkg::LEN_BITS_DEF);

   rat_pkg::phase_type parse_phase;
   logic               cr_seen;
   logic [63:0]        num_value;
   logic               num_has_digit;
   logic [63:0]        array_count;
   logic [63:0]        data_left;
   logic [63:0]        tokens_seen;
   logic [1:0]         skip_left;

   rat_pkg::rsp_type expected_tokens[$];

   function automatic void clear_parser();
      parse_phase   = rat_pkg::PH_ARR_START;
      cr_seen       = 1'b0;
      num_value     = '0;
      num_has_digit = 1'b0;
      array_count   = '0;
      data_left     = '0;
      tokens_seen   = '0;
      skip_left     = '0;
   endfunction

   function automatic void open_number(input rat_pkg::phase_type next_phase);
      parse_phase   = next_phase;
      cr_seen       = 1'b0;
      num_value     = '0;
      num_has_digit = 1'b0;
   endfunction

   function automatic void close_token();
      if (tokens_seen != {64{1'b1}}) begin
         tokens_seen = tokens_seen + 64'd1;
      end
      parse_phase = rat_pkg::PH_TRAILER;
      skip_left   = rat_pkg::TRAILER_LEN;
   endfunction

   // Returns 1 once the LF that ends a header number has arrived.
   function automatic logic number_byte(input logic [7:0] b);
      logic [63:0] digit;
      if (cr_seen) begin
         if (b != rat_pkg::CHAR_LF) begin
            parse_phase = rat_pkg::PH_STOP_REJ;
         end
         return b == rat_pkg::CHAR_LF;
      end
      if (b == rat_pkg::CHAR_CR) begin
         if (!num_has_digit) begin
            parse_phase = rat_pkg::PH_STOP_REJ;
         end else begin
            cr_seen = 1'b1;
         end
         return 1'b0;
      end
      if (b < rat_pkg::CHAR_ZERO || b > rat_pkg::CHAR_NINE) begin
         parse_phase = rat_pkg::PH_STOP_REJ;
         return 1'b0;
      end
      digit = {56'd0, 8'(b - rat_pkg::CHAR_ZERO)};
      if (num_value > (NUM_LIMIT - digit) / 64'd10) begin
         parse_phase = rat_pkg::PH_STOP_REJ;
         return 1'b0;
      end
      num_value     = num_value * 64'd10 + digit;
      num_has_digit = 1'b1;
      return 1'b0;
   endfunction

   function automatic rat_pkg::rsp_type tokenize_byte(input rat_pkg::req_type t);
      rat_pkg::rsp_type r;
      logic [7:0]       b;
      r = '0;
      b = t.in_byte;
      case (parse_phase)
         rat_pkg::PH_ARR_START: begin
            if (b == rat_pkg::CHAR_STAR) begin
               open_number(rat_pkg::PH_ARR_DIGITS);
            end else begin
               parse_phase = rat_pkg::PH_STOP_REJ;
            end
         end
         rat_pkg::PH_ARR_DIGITS: begin
            if (number_byte(b)) begin
               array_count = num_value;
               parse_phase = rat_pkg::PH_BULK_START;
            end
         end
         rat_pkg::PH_BULK_START: begin
            if (b == rat_pkg::CHAR_DOLLAR) begin
               open_number(rat_pkg::PH_BULK_DIGITS);
            end else begin
               parse_phase = rat_pkg::PH_STOP_PART;
            end
         end
         rat_pkg::PH_BULK_DIGITS: begin
            if (number_byte(b)) begin
               data_left = num_value;
               if (data_left == 64'd0) begin
                  r.token_last = 1'b1;
                  close_token();
               end else begin
                  parse_phase = rat_pkg::PH_DATA;
               end
            end
         end
         rat_pkg::PH_DATA: begin
            r.token_byte = b;
            r.byte_valid = 1'b1;
            data_left    = data_left - 64'd1;
            if (data_left == 64'd0) begin
               r.token_last = 1'b1;
               close_token();
            end
         end
         rat_pkg::PH_TRAILER: begin
            skip_left = skip_left - 2'd1;
            if (skip_left == 2'd0) begin
               parse_phase = rat_pkg::PH_BULK_START;
            end
         end
         default: begin
         end
      endcase
      if (t.in_last) begin
         r.msg_done = 1'b1;
         if (parse_phase == rat_pkg::PH_STOP_PART) begin
            r.verdict = rat_pkg::VERDICT_PARTIAL;
         end else if (parse_phase == rat_pkg::PH_BULK_START) begin
            r.verdict = (tokens_seen == array_count) ? rat_pkg::VERDICT_OK
                                                     : rat_pkg::VERDICT_REJECT;
         end else begin
            r.verdict = rat_pkg::VERDICT_REJECT;
         end
         clear_parser();
      end
      return r;
   endfunction

   always @(posedge clock) begin : watch
      rat_pkg::rsp_type want;
      if (reset) begin
         clear_parser();
         expected_tokens.delete();
         fail_count = 0;
      end else begin
         if (req_valid && !req_stall) begin
            expected_tokens.insert(expected_tokens.size(), tokenize_byte(req_data));
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_tokens.size() == 0) begin
               $display("%0t: unexpected result byte=%h valid=%b last=%b done=%b verdict=%0d",
                        $time, rsp_data.token_byte, rsp_data.byte_valid,
                        rsp_data.token_last, rsp_data.msg_done, rsp_data.verdict);
               fail_count = fail_count + 1;
            end else begin
               want = expected_tokens.pop_front();
               if (rsp_data !== want) begin
                  $display("%0t: mismatch expected byte=%h valid=%b last=%b done=%b verdict=%0d",
                           $time, want.token_byte, want.byte_valid, want.token_last,
                           want.msg_done, want.verdict,
                           " got byte=%h valid=%b last=%b done=%b verdict=%0d",
                           rsp_data.token_byte, rsp_data.byte_valid, rsp_data.token_last,
                           rsp_data.msg_done, rsp_data.verdict);
                  fail_count = fail_count + 1;
               end
            end
         end
      end
      pending = expected_tokens.size();
   end

endmodule

// ===== sim/tb_top.sv =====
// Testbench top for resp_array_tokenizer: drives directed and random messages byte by
// byte with random idling on both sides and gives the verdict.
// Depends on rat_pkg, resp_array_tokenizer and rat_token_checker.
`timescale 1ns / 1ps

module tb_top;

   localparam logic [63:0] NUM_LIMIT   = {64{1'b1}} >> (64 - rat_pkg::LEN_BITS_DEF);
   localparam int          TOTAL_BYTES = 1450;
   localparam int          QUIET_LIMIT = 2000;
   localparam int          TAIL_CYCLES = 8;

   logic             clock     = 1'b0;
   logic             reset     = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   rat_pkg::req_type req_data  = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   rat_pkg::rsp_type rsp_data;

   int fail_count;
   int pending;
   int quiet_cycles = 0;
   int bytes_sent   = 0;
   int send_idle    = 34;
   int recv_idle    = 57;

   logic [7:0] msg_q[$];

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   resp_array_tokenizer u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   rat_token_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data),
      .fail_count (fail_count),
      .pending    (pending)
   );

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < recv_idle);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("** resp_array_tokenizer: FAILED **");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic put_char(input logic [7:0] b);
      msg_q.insert(msg_q.size(), b);
   endtask

   task automatic put_crlf();
      msg_q.insert(msg_q.size(), rat_pkg::CHAR_CR);
      msg_q.insert(msg_q.size(), rat_pkg::CHAR_LF);
   endtask

   task automatic put_number(input logic [63:0] v, input int zeros);
      logic [7:0]  digs[$];
      logic [63:0] rem;
      repeat (zeros) msg_q.insert(msg_q.size(), rat_pkg::CHAR_ZERO);
      do begin
         rem = v % 64'd10;
         digs.push_front(rat_pkg::CHAR_ZERO + rem[7:0]);
         v = v / 64'd10;
      end while (v != 0);
      foreach (digs[i]) msg_q.insert(msg_q.size(), digs[i]);
   endtask

   function automatic logic [7:0] odd_byte();
      case ($urandom_range(4))
         0:       return rat_pkg::CHAR_CR;
         1:       return rat_pkg::CHAR_LF;
         2:       return rat_pkg::CHAR_DOLLAR;
         3:       return rat_pkg::CHAR_ZERO + 8'($urandom_range(9));
         default: return 8'($urandom_range(255));
      endcase
   endfunction

   task automatic put_group(input int len);
      put_char(rat_pkg::CHAR_DOLLAR);
      put_number(64'(len), ($urandom_range(9) == 0) ? $urandom_range(1, 2) : 0);
      put_crlf();
      repeat (len) put_char(8'($urandom_range(255)));
      if ($urandom_range(1)) begin
         put_crlf();
      end else begin
         put_char(8'($urandom_range(255)));
         put_char(8'($urandom_range(255)));
      end
   endtask

   task automatic send_byte(input logic [7:0] b, input logic last);
      while ($urandom_range(99) < send_idle) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_data.in_byte <= b;
      req_data.in_last <= last;
      do @(posedge clock); while (req_stall);
      bytes_sent = bytes_sent + 1;
   endtask

   // Send the first n bytes of the message; the final one carries the last flag.
   task automatic send_message(input int n);
      for (int i = 0; i < n; i++) begin
         send_byte(msg_q[i], i == n - 1);
      end
      msg_q.delete();
   endtask

   task automatic wait_for_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
   endtask

   task automatic build_message();
      int          mode;
      int          count;
      int          groups;
      int          idx;
      logic [63:0] big;
      mode = $urandom_range(99);
      if (mode < 8) begin
         if ($urandom_range(1)) put_char(rat_pkg::CHAR_STAR);
         repeat ($urandom_range(1, 6)) put_char(odd_byte());
      end else if (mode < 18) begin
         case ($urandom_range(4))
            0:       big = NUM_LIMIT;
            1:       big = NUM_LIMIT + 64'd1;
            2:       big = NUM_LIMIT - 64'd1;
            3:       big = {32'd0, $urandom()};
            default: big = {32'($urandom_range(30)), $urandom()};
         endcase
         put_char(rat_pkg::CHAR_STAR);
         if ($urandom_range(1)) begin
            put_number(big, $urandom_range(1));
            put_crlf();
            repeat ($urandom_range(2)) put_group($urandom_range(3));
         end else begin
            put_number(64'd1, 0);
            put_crlf();
            put_char(rat_pkg::CHAR_DOLLAR);
            put_number(big, $urandom_range(1));
            put_crlf();
            repeat ($urandom_range(4)) put_char(8'($urandom_range(255)));
         end
      end else begin
         count  = $urandom_range(3);
         groups = count;
         if ($urandom_range(6) == 0) begin
            groups = ($urandom_range(1) || count == 0) ? count + 1 : count - 1;
         end
         put_char(rat_pkg::CHAR_STAR);
         put_number(64'(count), ($urandom_range(9) == 0) ? $urandom_range(1, 2) : 0);
         put_crlf();
         repeat (groups) begin
            put_group(($urandom_range(4) == 0) ? $urandom_range(5, 16) : $urandom_range(3));
         end
         case ($urandom_range(9))
            0, 1: begin
               send_message($urandom_range(1, msg_q.size()));
               return;
            end
            2: begin
               idx = $urandom_range(msg_q.size() - 1);
               msg_q[idx] = odd_byte();
            end
            3: begin
               put_char(8'($urandom_range(35)));
               repeat ($urandom_range(3)) put_char(8'($urandom_range(255)));
            end
            default: begin
            end
         endcase
      end
      send_message(msg_q.size());
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // bad first byte
      put_char("A");
      send_message(msg_q.size());
      // empty number
      put_char(rat_pkg::CHAR_STAR);
      put_char(rat_pkg::CHAR_CR);
      send_message(msg_q.size());
      // missing LF after CR
      put_char(rat_pkg::CHAR_STAR);
      put_char("1");
      put_char(rat_pkg::CHAR_CR);
      put_char("Z");
      send_message(msg_q.size());
      // non-digit inside a number
      put_char(rat_pkg::CHAR_STAR);
      put_char("9");
      put_char("x");
      send_message(msg_q.size());
      // missing dollar, then a byte that must be ignored
      put_char(rat_pkg::CHAR_STAR);
      put_char("1");
      put_crlf();
      put_char("Q");
      put_char("Z");
      send_message(msg_q.size());
      // clean message with the extreme data values
      put_char(rat_pkg::CHAR_STAR);
      put_char("1");
      put_crlf();
      put_char(rat_pkg::CHAR_DOLLAR);
      put_char("2");
      put_crlf();
      put_char(8'h00);
      put_char(8'hFF);
      put_crlf();
      send_message(msg_q.size());

      wait_for_results();

      while (bytes_sent < TOTAL_BYTES) begin
         if (bytes_sent >= 2 * TOTAL_BYTES / 3) begin
            send_idle = 0;
            recv_idle = 0;
         end else if (bytes_sent >= TOTAL_BYTES / 3) begin
            send_idle = 57;
            recv_idle = 34;
         end
         build_message();
         if ($urandom_range(9) == 0) wait_for_results();
      end

      wait_for_results();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (fail_count == 0 && pending == 0) begin
         $display("** resp_array_tokenizer: PASSED **");
      end else begin
         $display("** resp_array_tokenizer: FAILED **");
      end
      $finish;
   end

endmodule

// ===== files.f =====
src/rat_pkg.sv
src/rat_core.sv
src/resp_array_tokenizer.sv
sim/rat_token_checker.sv
sim/tb_top.sv
